[rtl/gspk_pkg.sv]
// Shared types and constants for the grid state pairing key block.
package gspk_pkg;

  localparam int COORD_W    = 13;
  localparam int NUM_COORDS = 4;
  localparam int KEY_BITS   = 52;
  localparam int DIMS_W     = 3;
  localparam int NUM_STAGES = 6;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;

  // Per-cycle pipeline control from the top level to the datapath.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [DIMS_W-1:0]     dims;
  } pipe_ctrl_t;

endpackage

[rtl/gspk_if.sv]
// Valid/ready channel interfaces for coordinates, keys and configuration.
interface gspk_coord_if;
  logic                                valid;
  logic                                ready;
  logic signed [gspk_pkg::COORD_W-1:0] coord_0;
  logic signed [gspk_pkg::COORD_W-1:0] coord_1;
  logic signed [gspk_pkg::COORD_W-1:0] coord_2;
  logic signed [gspk_pkg::COORD_W-1:0] coord_3;

  modport source (output valid, coord_0, coord_1, coord_2, coord_3, input ready);
  modport sink (input valid, coord_0, coord_1, coord_2, coord_3, output ready);
  modport monitor (input valid, ready, coord_0, coord_1, coord_2, coord_3);
endinterface

interface gspk_key_if;
  logic                              valid;
  logic                              ready;
  logic [gspk_pkg::KEY_BITS-1:0]     pair_key;

  modport source (output valid, pair_key, input ready);
  modport sink (input valid, pair_key, output ready);
  modport monitor (input valid, ready, pair_key);
endinterface

interface gspk_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gspk_pkg::DIMS_W-1:0]   dims_in_use;

  modport source (output valid, dims_in_use, input ready);
  modport sink (input valid, dims_in_use, output ready);
  modport monitor (input valid, ready, dims_in_use);
endinterface

[rtl/gspk_core.sv]
// Six-stage datapath: zigzag mapping, running maxima, powers and the key sum.
module gspk_core #(
  parameter int COORD_BITS = 13
) (
  input  logic                                clk,
  input  gspk_pkg::pipe_ctrl_t                ctrl,
  input  logic signed [gspk_pkg::COORD_W-1:0] coord_0,
  input  logic signed [gspk_pkg::COORD_W-1:0] coord_1,
  input  logic signed [gspk_pkg::COORD_W-1:0] coord_2,
  input  logic signed [gspk_pkg::COORD_W-1:0] coord_3,
  output logic [gspk_pkg::KEY_BITS-1:0]       pair_key
);

  localparam int W    = COORD_BITS;
  localparam int KW   = gspk_pkg::KEY_BITS;
  localparam int DW   = gspk_pkg::DIMS_W;
  localparam int SQW  = 2 * W;
  localparam int CUW  = 3 * W;
  localparam int QW   = 4 * W;
  localparam int P3W  = 2 * W + 1;
  localparam int PLW  = 2 * W + 2;
  localparam int P4W  = 3 * W + 2;

  // Zigzag map: non-negative c becomes 2c, negative c becomes -2c-1.
  function automatic logic [W-1:0] zigzag(input logic [W-1:0] v);
    return {v[W-2:0], 1'b0} ^ {W{v[W-1]}};
  endfunction

  // Stage 1: mapped coordinates and clamped dimension count.
  logic [W-1:0]  s1 [gspk_pkg::NUM_COORDS];
  logic [DW-1:0] dims1;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1[0] <= zigzag(coord_0[W-1:0]);
      s1[1] <= zigzag(coord_1[W-1:0]);
      s1[2] <= zigzag(coord_2[W-1:0]);
      s1[3] <= zigzag(coord_3[W-1:0]);
      dims1 <= ctrl.dims;
    end
  end

  // Stage 2: running maxima and differences. An unused dimension gets zero
  // for both, which makes its whole term vanish.
  logic [W-1:0] mx2, mx3, mx4;
  logic [W-1:0] s0_2, m2_2, m3_2, m4_2, d2_2, d3_2, d4_2;

  always_comb begin
    mx2 = (s1[1] > s1[0]) ? s1[1] : s1[0];
    mx3 = (s1[2] > mx2) ? s1[2] : mx2;
    mx4 = (s1[3] > mx3) ? s1[3] : mx3;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s0_2 <= s1[0];
      m2_2 <= (dims1 >= DW'(2)) ? mx2 : '0;
      d2_2 <= (dims1 >= DW'(2)) ? (mx2 - s1[1]) : '0;
      m3_2 <= (dims1 >= DW'(3)) ? mx3 : '0;
      d3_2 <= (dims1 >= DW'(3)) ? (mx3 - s1[2]) : '0;
      m4_2 <= (dims1 >= DW'(4)) ? mx4 : '0;
      d4_2 <= (dims1 >= DW'(4)) ? (mx4 - s1[3]) : '0;
    end
  end

  // Stage 3: squares of the maxima.
  logic [W-1:0]   s0_3, d2_3, m3_3, d3_3, m4_3, d4_3;
  logic [SQW-1:0] sq2_3, sq3_3, sq4_3;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s0_3  <= s0_2;
      d2_3  <= d2_2;
      m3_3  <= m3_2;
      d3_3  <= d3_2;
      m4_3  <= m4_2;
      d4_3  <= d4_2;
      sq2_3 <= SQW'(m2_2) * SQW'(m2_2);
      sq3_3 <= SQW'(m3_2) * SQW'(m3_2);
      sq4_3 <= SQW'(m4_2) * SQW'(m4_2);
    end
  end

  // Stage 4: second-dimension term, cube, fourth power, the third-dimension
  // product and the difference of cubes (m+1)^3 - m^3 = 3m^2 + 3m + 1.
  logic [W-1:0]   s0_4, d4_4;
  logic [SQW:0]   term2_4;
  logic [CUW-1:0] cube3_4;
  logic [P3W-1:0] prod3_4;
  logic [QW-1:0]  quart4_4;
  logic [PLW-1:0] poly4_4;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s0_4     <= s0_3;
      d4_4     <= d4_3;
      term2_4  <= (SQW+1)'(sq2_3) + (SQW+1)'(d2_3);
      cube3_4  <= CUW'(sq3_3) * CUW'(m3_3);
      prod3_4  <= P3W'(d3_3) * P3W'({m3_3, 1'b1});
      quart4_4 <= QW'(sq4_3) * QW'(sq4_3);
      poly4_4  <= PLW'(sq4_3) + PLW'({sq4_3, 1'b0}) + PLW'(m4_3)
                + PLW'({m4_3, 1'b0}) + PLW'(1);
    end
  end

  // Stage 5: fourth-dimension product and the partial sum of the rest.
  logic [P4W-1:0] prod4_5;
  logic [KW-1:0]  part_5;
  logic [QW-1:0]  quart4_5;

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      prod4_5  <= P4W'(d4_4) * P4W'(poly4_4);
      part_5   <= KW'(s0_4) + KW'(term2_4) + KW'(cube3_4) + KW'(prod3_4);
      quart4_5 <= quart4_4;
    end
  end

  // Stage 6: final key, which is the output register.
  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      pair_key <= part_5 + KW'(quart4_5) + KW'(prod4_5);
    end
  end

endmodule

[rtl/grid_state_pairing_key.sv]
// Top level of the grid state pairing key block: handshake, config and pipeline control.
//
//   Channel  Role    Beat contents
//   coords   sink    coord_0 .. coord_3, signed grid coordinates
//   keys     source  pair_key, 52-bit unsigned pairing key
//   cfg      sink    dims_in_use, number of coordinates used per vector
//
// The block accepts one coordinate beat in every cycle, unless a stall on keys
// has filled every stage, and returns its key through six register stages. The
// datapath multipliers (squares, cube, fourth power, two products) are each
// followed by a register, in stages three to five of the pipeline.
// Reset clears the stage valid bits and sets dims_in_use to four.
// A stall on keys holds the output beat; stages behind it keep filling bubbles
// and the input is refused only once every stage holds a beat.
module grid_state_pairing_key #(
  parameter int MAX_DIM    = 4,
  parameter int COORD_BITS = 13
) (
  input logic          clk,
  input logic          rst,
  gspk_coord_if.sink   coords,
  gspk_key_if.source   keys,
  gspk_cfg_if.sink     cfg
);

  localparam int NS = gspk_pkg::NUM_STAGES;
  localparam int DW = gspk_pkg::DIMS_W;

  // The dimension count register. The configuration channel never stalls.
  logic [DW-1:0] dims_in_use;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= gspk_pkg::DIMS_RESET;
    end else if (cfg.valid) begin
      dims_in_use <= cfg.dims_in_use;
    end
  end

  // A count of zero is treated as one, and anything above the largest
  // supported dimension is treated as that dimension.
  logic [DW-1:0] dims_clamped;

  always_comb begin
    if (dims_in_use == '0) begin
      dims_clamped = DW'(1);
    end else if (dims_in_use > DW'(MAX_DIM)) begin
      dims_clamped = DW'(MAX_DIM);
    end else begin
      dims_clamped = dims_in_use;
    end
  end

  // Each stage loads when it is empty or when the stage after it loads, so a
  // bubble anywhere in the pipeline is squeezed out even during a stall.
  logic [NS-1:0] valid;
  gspk_pkg::pipe_ctrl_t ctrl;

  always_comb begin
    ctrl.dims = dims_clamped;
    ctrl.load[NS-1] = !valid[NS-1] || keys.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      ctrl.load[i] = !valid[i] || ctrl.load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctrl.load[0]) begin
        valid[0] <= coords.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (ctrl.load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign coords.ready = ctrl.load[0];
  assign keys.valid   = valid[NS-1];

  gspk_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk      (clk),
    .ctrl     (ctrl),
    .coord_0  (coords.coord_0),
    .coord_1  (coords.coord_1),
    .coord_2  (coords.coord_2),
    .coord_3  (coords.coord_3),
    .pair_key (keys.pair_key)
  );

endmodule

[rtl/gspk_checker.sv]
// Port-level checks on the grid state pairing key block, bound to its top level.
module gspk_checker (
  input logic        clk,
  input logic        rst,
  gspk_coord_if.sink coords,
  gspk_key_if.source keys,
  gspk_cfg_if.sink   cfg
);

  // A key beat that is not taken stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    keys.valid && !keys.ready |=> keys.valid && $stable(keys.pair_key))
    else $error("key beat changed while stalled");

  // With the output free, every stage can advance, so the input must be open.
  assert property (@(posedge clk) disable iff (rst)
    !keys.valid || keys.ready |-> coords.ready)
    else $error("input refused while the output stage could drain");

  // An all-zero vector maps to key zero at any dimension count, and with the
  // output open it emerges after exactly six stages.
  assert property (@(posedge clk) disable iff (rst)
    coords.valid && coords.ready && coords.coord_0 == '0 && coords.coord_1 == '0
      && coords.coord_2 == '0 && coords.coord_3 == '0
      ##1 keys.ready ##1 keys.ready ##1 keys.ready ##1 keys.ready ##1 keys.ready
    |=> keys.valid && keys.pair_key == '0)
    else $error("zero vector did not give key zero after six stages");

  // The configuration port takes every write.
  assert property (@(posedge clk) disable iff (rst)
    cfg.valid |-> cfg.ready)
    else $error("configuration write refused");

endmodule

bind grid_state_pairing_key gspk_checker u_gspk_checker (
  .clk    (clk),
  .rst    (rst),
  .coords (coords),
  .keys   (keys),
  .cfg    (cfg)
);
